/* src/ctlr_pkg.sv */
// ----------------------------------------------------------------------------
// ctlr_pkg
// Shared constants, codes and controller/datapath handshake types for the
// circle text line layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlr_pkg;

	// Default geometry: unsigned Q12.4 coordinates
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 4;

	// Fixed field widths
	localparam int CFG_IDX_W = 2;
	localparam int DIR_W     = 3;
	localparam int STATUS_W  = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd1;

	// Item kinds
	localparam logic KIND_LINE    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// Line status codes
	localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CROPPED = 2'd2;

	// Reading direction bits
	localparam int DIR_VERT  = 0;
	localparam int DIR_REV_P = 1;
	localparam int DIR_REV_S = 2;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic prep;
		logic mul_a;
		logic mul_b;
		logic sqrt_init;
		logic sqrt_step;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic quick;
		logic sqrt_last;
	} sts_t;

endpackage

`default_nettype wire

/* src/ctlr_ctrl.sv */
// ----------------------------------------------------------------------------
// ctlr_ctrl
// Sequencer for one item: capture, classify, square terms, root steps (skipped
// for quick items), then hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ctlr_pkg::cmd_t    cmd,
	input  ctlr_pkg::sts_t    sts
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PREP   = 3'd1;
	localparam logic [2:0] S_MULA   = 3'd2;
	localparam logic [2:0] S_MULB   = 3'd3;
	localparam logic [2:0] S_SQINIT = 3'd4;
	localparam logic [2:0] S_SQRT   = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load_in   = (state_q == S_IDLE) && in_valid;
		cmd.prep      = (state_q == S_PREP);
		cmd.mul_a     = (state_q == S_MULA);
		cmd.mul_b     = (state_q == S_MULB);
		cmd.sqrt_init = (state_q == S_SQINIT);
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.finish    = (state_q == S_FIN) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_PREP;
			end
			S_PREP: begin
				state_d = sts.quick ? S_FIN : S_MULA;
			end
			S_MULA:   state_d = S_MULB;
			S_MULB:   state_d = S_SQINIT;
			S_SQINIT: state_d = S_SQRT;
			S_SQRT: begin
				if (sts.sqrt_last) state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* src/ctlr_dp.sv */
// ----------------------------------------------------------------------------
// ctlr_dp
// Datapath: area registers, line offset, chord geometry, shared squarer,
// bit-per-step square root and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlr_dp #(
	parameter int COORD_BITS = ctlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = ctlr_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ctlr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_BITS-1:0]                cfg_data,
	input  logic                                 kind,
	input  logic [COORD_BITS-1:0]                line_height,
	input  logic [ctlr_pkg::DIR_W-1:0]           reading_direction,
	input  ctlr_pkg::cmd_t                       cmd,
	output ctlr_pkg::sts_t                       sts,
	output logic signed [COORD_BITS+1:0]         rect_left,
	output logic signed [COORD_BITS+1:0]         rect_top,
	output logic signed [COORD_BITS+1:0]         rect_right,
	output logic signed [COORD_BITS+1:0]         rect_bottom,
	output logic [ctlr_pkg::STATUS_W-1:0]        line_status
);

	localparam int C    = COORD_BITS;
	localparam int SQ_W = 2 * COORD_BITS;
	localparam int E    = COORD_BITS + 4;
	localparam logic signed [E-1:0] NEG_ONE = -$signed(E'(2) << FRAC_BITS);
	localparam logic [SQ_W-1:0]     BIT_TOP = {2'b01, {(SQ_W-2){1'b0}}};
	localparam logic [C:0]          OFFSET_MAX = '1;

	// Control state
	logic [C-1:0] area_w_q;
	logic [C-1:0] area_h_q;
	logic [C:0]   offset_q;

	// Captured item and classification
	logic                          kind_q;
	logic [C-1:0]                  h_q;
	logic [ctlr_pkg::DIR_W-1:0]    dir_q;
	logic [C-1:0]                  usz_q;
	logic [C-1:0]                  vsz_q;
	logic [C-1:0]                  mh_q;
	logic [C-1:0]                  absadj_q;
	logic                          outside_q;
	logic                          quick_q;
	logic                          restart_q;
	logic [ctlr_pkg::STATUS_W-1:0] code_q;

	// Squares and root
	logic [SQ_W-1:0] sqa_q;
	logic [SQ_W-1:0] sqb_q;
	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] root_q;
	logic [SQ_W-1:0] bit_q;

	// Result register
	logic signed [C+1:0]           rl_q, rt_q, rr_q, rb_q;
	logic [ctlr_pkg::STATUS_W-1:0] rs_q;

	// Classification
	logic                          vert_w;
	logic [C-1:0]                  usz_w, vsz_w, mh_w;
	logic                          restart_w, empty_w, full_w, quick_w;
	logic [ctlr_pkg::STATUS_W-1:0] code_w;
	logic [C+2:0]                  mid_w;
	logic [C+3:0]                  adj_w, negadj_w;
	logic [C+2:0]                  absadj_w;
	logic                          outside_w;

	// Squarer and root step
	logic [C-1:0]    mul_op;
	logic [SQ_W-1:0] prod_w;
	logic [SQ_W-1:0] trial_w;
	logic            take_w;

	// Geometry
	logic [C+1:0]        sum_oh;
	logic [C:0]          offset_next;
	logic signed [E-1:0] ud, us, vs, t0, b0, l0, r0, l1, r1, t1, b1;
	logic signed [E-1:0] lf, tf, rf, bf, hl, ht, hr, hb;

	assign cfg_ready = 1'b1;

	// Classify the captured item
	always_comb begin
		vert_w    = dir_q[ctlr_pkg::DIR_VERT];
		usz_w     = vert_w ? area_h_q : area_w_q;
		vsz_w     = vert_w ? area_w_q : area_h_q;
		mh_w      = (usz_w < vsz_w) ? usz_w : vsz_w;
		restart_w = (kind_q == ctlr_pkg::KIND_RESTART);
		empty_w   = (area_w_q == '0) || (area_h_q == '0);
		full_w    = (offset_q >= {1'b0, vsz_w});
		quick_w   = restart_w || empty_w || full_w;
		if (restart_w) begin
			code_w = ctlr_pkg::ST_PLACED;
		end else if (empty_w) begin
			code_w = ctlr_pkg::ST_EMPTY;
		end else if (full_w) begin
			code_w = ctlr_pkg::ST_CROPPED;
		end else begin
			code_w = ctlr_pkg::ST_PLACED;
		end
		// line middle minus area middle, in half-LSB units
		mid_w     = {1'b0, offset_q, 1'b0} + {3'b000, h_q};
		adj_w     = {1'b0, mid_w} - {4'b0000, vsz_w};
		negadj_w  = -adj_w;
		absadj_w  = adj_w[C+3] ? negadj_w[C+2:0] : adj_w[C+2:0];
		outside_w = (absadj_w >= {3'b000, mh_w});
	end

	assign sts.quick     = quick_w;
	assign sts.sqrt_last = bit_q[0];

	// One squarer, shared by both terms
	assign mul_op  = cmd.mul_b ? absadj_q : mh_q;
	assign prod_w  = mul_op * mul_op;
	assign trial_w = root_q + bit_q;
	assign take_w  = (rem_q >= trial_w);

	// Chord rectangle, mirrored and transposed
	always_comb begin
		ud = outside_q ? NEG_ONE : $signed({4'b0000, root_q[C-1:0]});
		us = $signed({4'b0000, usz_q});
		vs = $signed({4'b0000, vsz_q});
		sum_oh = {1'b0, offset_q} + {2'b00, h_q};
		t0 = $signed({2'b00, offset_q, 1'b0});
		b0 = $signed({1'b0, sum_oh, 1'b0});
		l0 = us - ud;
		r0 = us + ud;
		if (dir_q[ctlr_pkg::DIR_REV_P]) begin
			l1 = (us <<< 1) - r0;
			r1 = (us <<< 1) - l0;
		end else begin
			l1 = l0;
			r1 = r0;
		end
		if (dir_q[ctlr_pkg::DIR_REV_S]) begin
			t1 = (vs <<< 1) - b0;
			b1 = (vs <<< 1) - t0;
		end else begin
			t1 = t0;
			b1 = b0;
		end
		if (dir_q[ctlr_pkg::DIR_VERT]) begin
			lf = t1;
			tf = l1;
			rf = b1;
			bf = r1;
		end else begin
			lf = l1;
			tf = t1;
			rf = r1;
			bf = b1;
		end
		// halve with rounding toward minus infinity
		hl = lf >>> 1;
		ht = tf >>> 1;
		hr = rf >>> 1;
		hb = bf >>> 1;
		if (restart_q) begin
			offset_next = '0;
		end else if (quick_q) begin
			offset_next = offset_q;
		end else if (sum_oh[C+1]) begin
			offset_next = OFFSET_MAX;
		end else begin
			offset_next = sum_oh[C:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_w_q <= '0;
			area_h_q <= '0;
			offset_q <= '0;
		end else begin
			if (cfg_valid && cfg_index == ctlr_pkg::REG_AREA_WIDTH) begin
				area_w_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == ctlr_pkg::REG_AREA_HEIGHT) begin
				area_h_q <= cfg_data;
			end
			if (cmd.finish) begin
				offset_q <= offset_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= kind;
			h_q    <= line_height;
			dir_q  <= reading_direction;
		end
		if (cmd.prep) begin
			usz_q     <= usz_w;
			vsz_q     <= vsz_w;
			mh_q      <= mh_w;
			absadj_q  <= absadj_w[C-1:0];
			outside_q <= outside_w;
			quick_q   <= quick_w;
			restart_q <= restart_w;
			code_q    <= code_w;
		end
		if (cmd.mul_a) begin
			sqa_q <= prod_w;
		end
		if (cmd.mul_b) begin
			sqb_q <= prod_w;
		end
		if (cmd.sqrt_init) begin
			rem_q  <= sqa_q - sqb_q;
			root_q <= '0;
			bit_q  <= BIT_TOP;
		end
		if (cmd.sqrt_step) begin
			if (take_w) begin
				rem_q  <= rem_q - trial_w;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.finish) begin
			if (quick_q) begin
				rl_q <= '0;
				rt_q <= '0;
				rr_q <= '0;
				rb_q <= '0;
				rs_q <= code_q;
			end else begin
				rl_q <= hl[C+1:0];
				rt_q <= ht[C+1:0];
				rr_q <= hr[C+1:0];
				rb_q <= hb[C+1:0];
				rs_q <= ctlr_pkg::ST_PLACED;
			end
		end
	end

	assign rect_left   = rl_q;
	assign rect_top    = rt_q;
	assign rect_right  = rr_q;
	assign rect_bottom = rb_q;
	assign line_status = rs_q;

endmodule

`default_nettype wire

/* src/circle_text_line_rect.sv */
// A line request passes through classify, the squaring of each term, root init,
// one square root step per cycle over COORD_BITS steps and the finish step; restart,
// empty and full items go from classify straight to finish. Finish waits while the
// output register still holds an untaken result. One item at a time; the next
// transfer is taken once the previous result sits in the output register.
// Reset (arst_n low, asynchronous): area registers and line offset clear, no
// result is valid, the block is ready for a transfer.
`default_nettype none

// ----------------------------------------------------------------------------
// circle_text_line_rect
// Places text lines inside the circle inscribed in the layout area and returns
// each line's rectangle in signed fixed point.
// ----------------------------------------------------------------------------
module circle_text_line_rect #(
	parameter int COORD_BITS = ctlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = ctlr_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ctlr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_BITS-1:0]            cfg_data,
	// line request channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [COORD_BITS-1:0]            line_height,
	input  logic [ctlr_pkg::DIR_W-1:0]       reading_direction,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [COORD_BITS+1:0]     rect_left,
	output logic signed [COORD_BITS+1:0]     rect_top,
	output logic signed [COORD_BITS+1:0]     rect_right,
	output logic signed [COORD_BITS+1:0]     rect_bottom,
	output logic [ctlr_pkg::STATUS_W-1:0]    line_status
);

	// Commands from the sequencer, status back from the datapath
	ctlr_pkg::cmd_t cmd;
	ctlr_pkg::sts_t sts;

	// Sequencer: holds the item through classify, square, root and finish, with
	// no square or root for quick items; finish waits for a free output register.
	ctlr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: all geometry runs in half-LSB units, so the line middle is
	// 2*offset + height and the chord half width is floor(sqrt(r^2 - dy^2)).
	ctlr_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.kind              (kind),
		.line_height       (line_height),
		.reading_direction (reading_direction),
		.cmd               (cmd),
		.sts               (sts),
		.rect_left         (rect_left),
		.rect_top          (rect_top),
		.rect_right        (rect_right),
		.rect_bottom       (rect_bottom),
		.line_status       (line_status)
	);

endmodule

`default_nettype wire

/* src/ctlr_chk.sv */
// ----------------------------------------------------------------------------
// ctlr_chk
// Port-level checks for the circle text line layout block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlr_chk #(
	parameter int COORD_BITS = ctlr_pkg::COORD_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [COORD_BITS+1:0]     rect_left,
	input logic signed [COORD_BITS+1:0]     rect_top,
	input logic signed [COORD_BITS+1:0]     rect_right,
	input logic signed [COORD_BITS+1:0]     rect_bottom,
	input logic [ctlr_pkg::STATUS_W-1:0]    line_status
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rect_left) &&
		$stable(rect_top) && $stable(rect_right) && $stable(rect_bottom) &&
		$stable(line_status))
	else $error("stalled result changed");

	// One item in flight: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("second item taken while one is in work");

	// A result never appears in the cycle right after a transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
	else $error("result too early");

	// Empty or cropped lines give a zero rectangle
	a_zero_rect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (line_status == ctlr_pkg::ST_EMPTY ||
		line_status == ctlr_pkg::ST_CROPPED) |->
		rect_left == '0 && rect_top == '0 && rect_right == '0 && rect_bottom == '0)
	else $error("nonzero rectangle for unplaced line");

	// Status is one of the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_status == ctlr_pkg::ST_PLACED ||
		line_status == ctlr_pkg::ST_EMPTY || line_status == ctlr_pkg::ST_CROPPED)
	else $error("undefined line status");

endmodule

bind circle_text_line_rect ctlr_chk #(.COORD_BITS(COORD_BITS)) u_ctlr_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.rect_left   (rect_left),
	.rect_top    (rect_top),
	.rect_right  (rect_right),
	.rect_bottom (rect_bottom),
	.line_status (line_status)
);

`default_nettype wire
